### hw/rtl/irpwd_pkg.sv
`default_nettype none

package irpwd_pkg;

  localparam int TS_W            = 16;
  localparam int CODE_W          = 21;
  localparam int SLOT_W          = 5;
  localparam int SLOT_EXT_W      = SLOT_W + 1;
  localparam int FRAME_SLOTS_DEF = 21;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 32;
  localparam int REG_IDX_W       = 3;

  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_MIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_MAX = 3'd5;

  localparam logic [TS_W-1:0] ONE_MIN_RST  = 16'd750;
  localparam logic [TS_W-1:0] ONE_MAX_RST  = 16'd800;
  localparam logic [TS_W-1:0] ZERO_MIN_RST = 16'd340;
  localparam logic [TS_W-1:0] ZERO_MAX_RST = 16'd410;
  localparam logic [TS_W-1:0] LEAD_MIN_RST = 16'd1500;
  localparam logic [TS_W-1:0] LEAD_MAX_RST = 16'd1800;

  typedef struct packed {
    logic [TS_W-1:0] one_min;
    logic [TS_W-1:0] one_max;
    logic [TS_W-1:0] zero_min;
    logic [TS_W-1:0] zero_max;
    logic [TS_W-1:0] lead_min;
    logic [TS_W-1:0] lead_max;
  } win_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/ir_pulse_width_frame_decoder.sv
// flow: an accepted edge waits in the input register until the output side can
// advance; a frame's last edge then has its code registered for the master side
// throughput: one edge per cycle unless output stalls; single state update stage
// reset: asynchronous, active low; clears the pipeline valids, the slot count
// and the edge state, loads the window registers and the frame store defaults
`default_nettype none

module ir_pulse_width_frame_decoder
  import irpwd_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,   // timestamp[15:0]
  input  wire logic                  s_axis_tuser,   // rising
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [23:0]           m_axis_tdata    // code[20:0], zero pad
);

  win_cfg_t           cfg;
  logic               in_vld_q, in_vld_d;
  logic               rising_q;
  logic [TS_W-1:0]    ts_q;
  logic               out_vld_q, out_vld_d;
  logic [CODE_W-1:0]  code_q;
  logic               advance;
  logic               in_take;
  logic               step;
  logic               res_vld;
  logic [CODE_W-1:0]  res_code;

  irpwd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  irpwd_pulse_core #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .rising_i    (rising_q),
    .timestamp_i (ts_q),
    .res_vld_o   (res_vld),
    .res_code_o  (res_code)
  );

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign step          = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  assign out_vld_d = advance ? res_vld : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rising_q <= s_axis_tuser;
      ts_q     <= s_axis_tdata;
    end
    if (advance && res_vld) begin
      code_q <= res_code;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = 24'(code_q);

endmodule

`default_nettype wire

### hw/rtl/irpwd_cfg_regs.sv
`default_nettype none

module irpwd_cfg_regs
  import irpwd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output win_cfg_t                   cfg_o
);

  win_cfg_t                 cfg_q;
  win_cfg_t                 cfg_d;
  logic [REG_IDX_W-1:0]     idx;
  logic [TS_W-1:0]          wval;
  logic [TS_W-1:0]          rval;
  logic                     wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wval   = pwdata[TS_W-1:0];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ONE_MIN:  cfg_d.one_min  = wval;
        REG_ONE_MAX:  cfg_d.one_max  = wval;
        REG_ZERO_MIN: cfg_d.zero_min = wval;
        REG_ZERO_MAX: cfg_d.zero_max = wval;
        REG_LEAD_MIN: cfg_d.lead_min = wval;
        REG_LEAD_MAX: cfg_d.lead_max = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ONE_MIN:  rval = cfg_q.one_min;
      REG_ONE_MAX:  rval = cfg_q.one_max;
      REG_ZERO_MIN: rval = cfg_q.zero_min;
      REG_ZERO_MAX: rval = cfg_q.zero_max;
      REG_LEAD_MIN: rval = cfg_q.lead_min;
      REG_LEAD_MAX: rval = cfg_q.lead_max;
      default:      rval = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rval);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_min  <= ONE_MIN_RST;
      cfg_q.one_max  <= ONE_MAX_RST;
      cfg_q.zero_min <= ZERO_MIN_RST;
      cfg_q.zero_max <= ZERO_MAX_RST;
      cfg_q.lead_min <= LEAD_MIN_RST;
      cfg_q.lead_max <= LEAD_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/irpwd_pulse_core.sv
`default_nettype none

module irpwd_pulse_core
  import irpwd_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire win_cfg_t          cfg_i,
  input  wire logic              step_i,
  input  wire logic              rising_i,
  input  wire logic [TS_W-1:0]   timestamp_i,
  output logic                   res_vld_o,
  output logic      [CODE_W-1:0] res_code_o
);

  localparam int PadW = (FRAME_SLOTS > CODE_W) ? FRAME_SLOTS : CODE_W;
  localparam logic [FRAME_SLOTS-1:0] StoreRst = FRAME_SLOTS'(1) << (FRAME_SLOTS - 2);

  logic                    await_q, await_d;
  logic [TS_W-1:0]         start_q, start_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [FRAME_SLOTS-1:0]  store_q, store_d;

  logic [TS_W-1:0]         width;
  logic                    lead_bad;
  logic [SLOT_W-1:0]       slot_eff;
  logic                    one_hit;
  logic                    zero_hit;
  logic [SLOT_EXT_W-1:0]   bit_idx;
  logic [SLOT_EXT_W-1:0]   slot_next;
  logic [PadW-1:0]         store_ext;

  assign width    = timestamp_i - start_q;
  assign lead_bad = (width > cfg_i.lead_max) || (width < cfg_i.lead_min);
  assign slot_eff = (slot_q == SLOT_W'(1) && lead_bad) ? '0 : slot_q;
  assign one_hit  = (width > cfg_i.one_min) && (width < cfg_i.one_max) &&
                    (slot_eff != SLOT_W'(1));
  assign zero_hit = (width > cfg_i.zero_min) && (width < cfg_i.zero_max);
  assign bit_idx  = SLOT_EXT_W'(FRAME_SLOTS - 1) - {1'b0, slot_eff};
  assign slot_next = {1'b0, slot_eff} + SLOT_EXT_W'(1);

  always_comb begin
    await_d   = await_q;
    start_d   = start_q;
    slot_d    = slot_q;
    store_d   = store_q;
    res_vld_o = 1'b0;
    if (step_i) begin
      if (!await_q) begin
        if (!rising_i) begin
          start_d = timestamp_i;
          await_d = 1'b1;
        end
      end else if (rising_i) begin
        await_d = 1'b0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
          if (SLOT_EXT_W'(i) == bit_idx) begin
            if (one_hit) begin
              store_d[i] = 1'b1;
            end else if (zero_hit) begin
              store_d[i] = 1'b0;
            end
          end
        end
        if (slot_next == SLOT_EXT_W'(FRAME_SLOTS)) begin
          slot_d    = '0;
          res_vld_o = 1'b1;
        end else begin
          slot_d = slot_next[SLOT_W-1:0];
        end
      end
    end
  end

  assign store_ext  = PadW'(store_d);
  assign res_code_o = store_ext[CODE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
      start_q <= '0;
      slot_q  <= '0;
      store_q <= StoreRst;
    end else begin
      await_q <= await_d;
      start_q <= start_d;
      slot_q  <= slot_d;
      store_q <= store_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/irpwd_checker.sv
`default_nettype none

module irpwd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // no result right out of reset
  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // input side never blocks while the output side can move
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind ir_pulse_width_frame_decoder irpwd_checker u_irpwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
